[src/sbo_pkg.sv]
// Shared types and constants for the segment versus obstacle-box checker.
// Used by the box table, the cross-product compare unit and the top level.
// No dependencies.
package sbo_pkg;

  // Item modes.
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // Field widths.
  localparam int CoordW = 24;
  localparam int HalfW  = 23;
  localparam int ClrW   = 16;
  // Grown box bounds, slab numerators, denominators and products.
  localparam int BoundW = 26;
  localparam int NumW   = 27;
  localparam int DenW   = 26;
  localparam int ProdW  = NumW + DenW;

  // One stored obstacle box.
  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic [HalfW-1:0]         hx;
    logic [HalfW-1:0]         hy;
  } box_t;

  // Operands of one cross compare: a*b against c*e.
  typedef struct packed {
    logic signed [NumW-1:0] a;
    logic signed [DenW-1:0] b;
    logic signed [NumW-1:0] c;
    logic signed [DenW-1:0] e;
  } cross_op_t;

  // Result of one cross compare.
  typedef struct packed {
    logic pos;  // a*b > c*e
    logic neg;  // a*b < c*e
  } cross_cmp_t;

endpackage

[src/sbo_table.sv]
// Obstacle box table: one write port, one registered read port.
// Depends on sbo_pkg for the box word type.
module sbo_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  sbo_pkg::box_t   wr_data,
  input  logic [AW-1:0]   rd_addr,
  output sbo_pkg::box_t   rd_data
);
  import sbo_pkg::*;

  box_t mem [DEPTH];

  // Write on add, read every cycle into the output register.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/sbo_cross_unit.sv]
// Shared cross-multiplication compare unit: registers a*b and c*e,
// then compares the two products. Depends on sbo_pkg.
module sbo_cross_unit (
  input  logic                  clk,
  input  sbo_pkg::cross_op_t    op,
  output sbo_pkg::cross_cmp_t   cmp
);
  import sbo_pkg::*;

  logic signed [NumW-1:0]  a;
  logic signed [DenW-1:0]  b;
  logic signed [NumW-1:0]  c;
  logic signed [DenW-1:0]  e;
  logic signed [ProdW-1:0] p1;
  logic signed [ProdW-1:0] p2;

  assign a = op.a;
  assign b = op.b;
  assign c = op.c;
  assign e = op.e;

  // Both products are registered before the compare.
  always_ff @(posedge clk) begin
    p1 <= ProdW'(a) * ProdW'(b);
    p2 <= ProdW'(c) * ProdW'(e);
  end

  assign cmp.pos = (p1 > p2);
  assign cmp.neg = (p1 < p2);

endmodule

[src/segment_box_obstacle_checker.sv]
// Top level of the segment versus obstacle-box checker.
// Depends on sbo_pkg, sbo_table and sbo_cross_unit.
//
// Usage:
//   Input words arrive on in_valid/in_ready; each word is a clear, an add
//   or a query (mode). Every word gives exactly one result word on
//   out_valid/out_ready carrying status, segment_hit and path_hit.
//   The user must write the clearance register through cfg_wr_en/cfg_wr_data
//   only while the block is idle; the block itself does not enforce this.
// Sequence:
//   A clear, an add or a mode 3 word passes from idle straight to the result
//   state. A query walks the table one box at a time through one shared
//   cross-multiply compare unit: each box takes a table read, a bounds step,
//   then up to five multiply/compare steps, each a multiply state and a
//   compare state. A query stops at the first box that is hit. in_ready is
//   high only while no word is at work.
// Reset:
//   rst clears the box count, the path hit accumulator, the clearance and
//   all handshake state; the table contents are left as they are.
// Stall:
//   A result waits in the output register; while it waits, one more word
//   can be taken and worked on, and its result holds until the output
//   register is free.
module segment_box_obstacle_checker #(
  parameter int MAX_BOXES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [sbo_pkg::ClrW-1:0]            cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          mode,
  input  logic signed [sbo_pkg::CoordW-1:0]   box_center_x,
  input  logic signed [sbo_pkg::CoordW-1:0]   box_center_y,
  input  logic [sbo_pkg::HalfW-1:0]           box_half_x,
  input  logic [sbo_pkg::HalfW-1:0]           box_half_y,
  input  logic signed [sbo_pkg::CoordW-1:0]   seg_start_x,
  input  logic signed [sbo_pkg::CoordW-1:0]   seg_start_y,
  input  logic signed [sbo_pkg::CoordW-1:0]   seg_end_x,
  input  logic signed [sbo_pkg::CoordW-1:0]   seg_end_y,
  input  logic                                last_segment,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                status,
  output logic                                segment_hit,
  output logic                                path_hit
);
  import sbo_pkg::*;

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_BOXES);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_BOUND,
    S_XE_MUL, S_XE_CMP, S_XX_MUL, S_XX_CMP,
    S_YE_MUL, S_YE_CMP, S_YX_MUL, S_YX_CMP,
    S_FIN_MUL, S_FIN_CMP, S_DONE
  } state_t;

  state_t state;

  logic [ClrW-1:0] clearance;
  logic [CW-1:0]   box_count;
  logic            hit_acc;
  logic [CW-1:0]   k;

  // Latched query word.
  logic signed [CoordW-1:0] sx, sy, ex, ey;
  logic                     last_q;

  // Per-box slab values.
  logic signed [NumW-1:0] ne_x, nx_x, ne_y, nx_y;
  logic signed [DenW-1:0] mag_x, mag_y;
  logic                   dy_zero;
  logic signed [NumW-1:0] enter_n, exit_n;
  logic signed [DenW-1:0] enter_d, exit_d;

  // Pending result.
  logic r_status, r_seg, r_path;

  box_t       wr_box;
  box_t       rd_box;
  cross_op_t  op;
  cross_cmp_t cmp;
  logic       tbl_wr;

  assign wr_box   = '{cx: box_center_x, cy: box_center_y, hx: box_half_x, hy: box_half_y};
  assign in_ready = (state == S_IDLE);
  assign tbl_wr   = in_valid && in_ready && (mode == MODE_ADD) && (box_count < MaxCount);

  sbo_table #(.DEPTH(MAX_BOXES), .AW(AW)) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (box_count[AW-1:0]),
    .wr_data (wr_box),
    .rd_addr (k[AW-1:0]),
    .rd_data (rd_box)
  );

  sbo_cross_unit u_cross (
    .clk (clk),
    .op  (op),
    .cmp (cmp)
  );

  // Grown bounds and slab numerators of the box just read.
  logic signed [BoundW-1:0] lox, hix, loy, hiy, sxw, syw;
  logic signed [DenW-1:0]   dx, dy;
  logic signed [NumW-1:0]   bne_x, bnx_x, bne_y, bnx_y;
  logic signed [DenW-1:0]   bmag_x, bmag_y;
  logic                     in_x, in_y;

  always_comb begin
    lox = BoundW'(rd_box.cx) - $signed({3'b000, rd_box.hx})
          - $signed({10'd0, clearance});
    hix = BoundW'(rd_box.cx) + $signed({3'b000, rd_box.hx})
          + $signed({10'd0, clearance});
    loy = BoundW'(rd_box.cy) - $signed({3'b000, rd_box.hy})
          - $signed({10'd0, clearance});
    hiy = BoundW'(rd_box.cy) + $signed({3'b000, rd_box.hy})
          + $signed({10'd0, clearance});
    sxw = BoundW'(sx);
    syw = BoundW'(sy);
    dx  = DenW'(ex) - DenW'(sx);
    dy  = DenW'(ey) - DenW'(sy);
    in_x = (sxw >= lox) && (sxw <= hix);
    in_y = (syw >= loy) && (syw <= hiy);
    if (dx[DenW-1]) begin
      bne_x  = NumW'(sxw) - NumW'(hix);
      bnx_x  = NumW'(sxw) - NumW'(lox);
      bmag_x = -dx;
    end else begin
      bne_x  = NumW'(lox) - NumW'(sxw);
      bnx_x  = NumW'(hix) - NumW'(sxw);
      bmag_x = dx;
    end
    if (dy[DenW-1]) begin
      bne_y  = NumW'(syw) - NumW'(hiy);
      bnx_y  = NumW'(syw) - NumW'(loy);
      bmag_y = -dy;
    end else begin
      bne_y  = NumW'(loy) - NumW'(syw);
      bnx_y  = NumW'(hiy) - NumW'(syw);
      bmag_y = dy;
    end
  end

  // Operand select for the shared compare unit.
  always_comb begin
    case (state)
      S_XE_MUL:  op = '{a: ne_x, b: enter_d, c: enter_n, e: mag_x};
      S_XX_MUL:  op = '{a: nx_x, b: exit_d,  c: exit_n,  e: mag_x};
      S_YE_MUL:  op = '{a: ne_y, b: enter_d, c: enter_n, e: mag_y};
      S_YX_MUL:  op = '{a: nx_y, b: exit_d,  c: exit_n,  e: mag_y};
      default:   op = '{a: enter_n, b: exit_d, c: exit_n, e: enter_d};
    endcase
  end

  // Next box, or a miss when the table is exhausted.
  logic          last_box;
  logic [CW-1:0] k_inc;
  assign k_inc    = k + CW'(1);
  assign last_box = (k_inc >= box_count);

  // Sequencer with the result and handshake registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clearance <= '0;
      box_count <= '0;
      hit_acc   <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (cfg_wr_en) begin
        clearance <= cfg_wr_data;
      end
      // The result register empties on a taken word unless a new one loads.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_status <= 1'b0;
            r_seg    <= 1'b0;
            r_path   <= 1'b0;
            sx <= seg_start_x;
            sy <= seg_start_y;
            ex <= seg_end_x;
            ey <= seg_end_y;
            last_q <= last_segment;
            k <= '0;
            state <= S_DONE;
            case (mode)
              MODE_CLEAR: box_count <= '0;
              MODE_ADD: begin
                if (box_count < MaxCount) begin
                  box_count <= box_count + CW'(1);
                end else begin
                  r_status <= 1'b1;
                end
              end
              MODE_QUERY: begin
                if (box_count == '0) begin
                  r_path  <= hit_acc;
                  hit_acc <= hit_acc && !last_segment;
                end else begin
                  state <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_READ: state <= S_BOUND;
        S_BOUND: begin
          ne_x <= bne_x; nx_x <= bnx_x; mag_x <= bmag_x;
          ne_y <= bne_y; nx_y <= bnx_y; mag_y <= bmag_y;
          dy_zero <= (dy == '0);
          enter_n <= '0;
          enter_d <= DenW'(1);
          exit_n  <= NumW'(1);
          exit_d  <= DenW'(1);
          if (((dx == '0) && !in_x) || ((dy == '0) && !in_y)) begin
            // Start lies outside a slab that the segment runs along.
            k <= k_inc;
            state <= last_box ? S_FIN_CMP : S_READ;
          end else if (dx != '0) begin
            state <= S_XE_MUL;
          end else if (dy != '0) begin
            state <= S_YE_MUL;
          end else begin
            state <= S_FIN_MUL;
          end
        end
        S_XE_MUL: state <= S_XE_CMP;
        S_XE_CMP: begin
          if (cmp.pos) begin
            enter_n <= ne_x;
            enter_d <= mag_x;
          end
          state <= S_XX_MUL;
        end
        S_XX_MUL: state <= S_XX_CMP;
        S_XX_CMP: begin
          if (cmp.neg) begin
            exit_n <= nx_x;
            exit_d <= mag_x;
          end
          state <= dy_zero ? S_FIN_MUL : S_YE_MUL;
        end
        S_YE_MUL: state <= S_YE_CMP;
        S_YE_CMP: begin
          if (cmp.pos) begin
            enter_n <= ne_y;
            enter_d <= mag_y;
          end
          state <= S_YX_MUL;
        end
        S_YX_MUL: state <= S_YX_CMP;
        S_YX_CMP: begin
          if (cmp.neg) begin
            exit_n <= nx_y;
            exit_d <= mag_y;
          end
          state <= S_FIN_MUL;
        end
        S_FIN_MUL: state <= S_FIN_CMP;
        S_FIN_CMP: begin
          // Reached with the unit holding the final test, or after a miss
          // on the last box (k already past the count).
          if ((k < box_count) && !cmp.pos) begin
            r_seg   <= 1'b1;
            r_path  <= 1'b1;
            hit_acc <= !last_q;
            state   <= S_DONE;
          end else if ((k < box_count) && !last_box) begin
            k     <= k_inc;
            state <= S_READ;
          end else begin
            r_path  <= hit_acc;
            hit_acc <= hit_acc && !last_q;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= r_status;
            segment_hit <= r_seg;
            path_hit    <= r_path;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/sbo_checker.sv]
// Port-level checks of the segment versus obstacle-box checker,
// bound to the top level. Depends only on the top level's ports.
module sbo_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic status,
  input logic segment_hit,
  input logic path_hit
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({status, segment_hit, path_hit}))
    else $error("result word changed while stalled");

  // A dropped add never reports a hit.
  a_status_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !segment_hit && !path_hit)
    else $error("status and hit both set");

  // A segment hit is always part of the path hit.
  a_seg_in_path: assert property (@(posedge clk) disable iff (rst)
    out_valid && segment_hit |-> path_hit)
    else $error("segment hit without path hit");

  // The block is busy right after taking a word.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

endmodule

bind segment_box_obstacle_checker sbo_checker u_sbo_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .segment_hit (segment_hit),
  .path_hit    (path_hit)
);
